### src/wfa_pkg.sv
`default_nettype none
package wfa_pkg;

  // Request kinds carried on in_tuser.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  // Fixed field widths of the stream payloads.
  localparam int unsigned HOLE_COUNT_W = 7;
  localparam int unsigned INDEX_W      = 6;
  localparam int unsigned FIELD_SIZE_W = 16;
  localparam int unsigned EXT_W        = 22;

  // Input tdata layout, lowest bit first.
  localparam int unsigned IN_IDX_LSB  = 0;
  localparam int unsigned IN_LOAD_LSB = IN_IDX_LSB + INDEX_W;
  localparam int unsigned IN_REQ_LSB  = IN_LOAD_LSB + FIELD_SIZE_W;
  localparam int unsigned IN_USED_W   = IN_REQ_LSB + FIELD_SIZE_W;
  localparam int unsigned IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int unsigned OUT_IDX_LSB  = 0;
  localparam int unsigned OUT_SIZE_LSB = OUT_IDX_LSB + INDEX_W;
  localparam int unsigned OUT_INT_LSB  = OUT_SIZE_LSB + FIELD_SIZE_W;
  localparam int unsigned OUT_EXT_LSB  = OUT_INT_LSB + FIELD_SIZE_W;
  localparam int unsigned OUT_ANY_LSB  = OUT_EXT_LSB + EXT_W;
  localparam int unsigned OUT_USED_W   = OUT_ANY_LSB + 1;
  localparam int unsigned OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [EXT_W-1:0] EXT_MAX = {EXT_W{1'b1}};

endpackage
`default_nettype wire

### src/wfa_ram.sv
`default_nettype none
module wfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/worst_fit_partition_allocator.sv
`default_nettype none
// Worst-fit fixed-partition allocator. A load beat (in_tuser 0) writes one hole size into
// the table and frees that hole, and gives no result. An allocate beat
// (in_tuser 1) walks the first min(hole_count, HOLES) entries, one entry per cycle through
// the single read port of the hole-size RAM, tracking the largest free hole (lowest index on
// a tie) and the saturated sum of free sizes. After an allocate beat, no further beat is
// accepted until its result has been loaded into the output register, and that load waits
// while a previous result is still held there unaccepted. Hole sizes are unknown until
// loaded; requesting over a never-loaded hole gives undefined result fields.
module worst_fit_partition_allocator #(
  parameter int unsigned HOLES     = 64,
  parameter int unsigned SIZE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [wfa_pkg::HOLE_COUNT_W-1:0]  cfg_wdata,   // hole_count
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // hole_index [5:0], load_size [21:6], request_size [37:22], zero fill above
  input  wire logic [wfa_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                              in_tuser,    // func
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // chosen_index [5:0], chosen_size [21:6], internal_frag [37:22],
  // free_total [59:38], any_free [60], zero fill above
  output logic      [wfa_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                   out_tuser    // granted
);

  import wfa_pkg::*;

  localparam int unsigned IDX_W = (HOLES > 1) ? $clog2(HOLES) : 1;
  localparam int unsigned CNT_W = $clog2(HOLES + 1);
  localparam int unsigned SUM_W = ((SIZE_BITS > EXT_W) ? SIZE_BITS : EXT_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [HOLE_COUNT_W-1:0] hole_count_r;
  logic [HOLES-1:0]       taken_r, taken_nxt;
  logic [CNT_W-1:0]       rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]       lim_r, lim_nxt;
  logic [SIZE_BITS-1:0]   req_r, req_nxt;
  logic                   p_valid_r, p_valid_nxt;
  logic                   p_taken_r, p_taken_nxt;
  logic [IDX_W-1:0]       p_idx_r, p_idx_nxt;
  logic                   found_r, found_nxt;
  logic [SIZE_BITS-1:0]   best_r, best_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [EXT_W-1:0]       ext_r, ext_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;

  logic                   in_fire;
  logic [31:0]            idx32, count32, lim32, load32, req32;
  logic [IDX_W-1:0]       ld_addr, rd_addr;
  logic                   ld_we;
  logic [SIZE_BITS-1:0]   rd_data;
  logic [SUM_W-1:0]       sum;
  logic                   grant, fin_load;
  logic [31:0]            out_idx32, out_size32, out_int32;

  // Input field extraction.
  assign in_fire = in_tvalid && in_tready;
  assign idx32   = 32'(in_tdata[IN_IDX_LSB +: INDEX_W]);
  assign load32  = 32'(in_tdata[IN_LOAD_LSB +: FIELD_SIZE_W]);
  assign req32   = 32'(in_tdata[IN_REQ_LSB +: FIELD_SIZE_W]);
  assign ld_addr = idx32[IDX_W-1:0];
  assign ld_we   = in_fire && (in_tuser == FUNC_LOAD) && (idx32 < 32'(HOLES));
  assign rd_addr = rd_cnt_r[IDX_W-1:0];
  assign count32 = 32'(hole_count_r);
  assign lim32   = (count32 > 32'(HOLES)) ? 32'(HOLES) : count32;

  wfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (HOLES)
  ) u_sizes (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_addr),
    .wdata (load32[SIZE_BITS-1:0]),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Free-size accumulation with saturation at the field maximum.
  assign sum = SUM_W'(ext_r) + SUM_W'(rd_data);

  assign grant      = found_r && (best_r >= req_r);
  assign fin_load   = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign out_idx32  = 32'(best_idx_r);
  assign out_size32 = 32'(best_r);
  assign out_int32  = 32'(best_r - req_r);

  always_comb begin
    state_nxt     = state_r;
    taken_nxt     = taken_r;
    rd_cnt_nxt    = rd_cnt_r;
    lim_nxt       = lim_r;
    req_nxt       = req_r;
    p_valid_nxt   = 1'b0;
    p_taken_nxt   = taken_r[rd_addr];
    p_idx_nxt     = rd_addr;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    ext_nxt       = ext_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    // Compare and accumulate stage, fed by the registered RAM read.
    if (p_valid_r && !p_taken_r) begin
      found_nxt = 1'b1;
      if (!found_r || (rd_data > best_r)) begin
        best_nxt     = rd_data;
        best_idx_nxt = p_idx_r;
      end
      ext_nxt = (sum > SUM_W'(EXT_MAX)) ? EXT_MAX : sum[EXT_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == FUNC_LOAD) begin
            if (ld_we) begin
              taken_nxt[ld_addr] = 1'b0;
            end
          end else begin
            req_nxt      = req32[SIZE_BITS-1:0];
            lim_nxt      = lim32[CNT_W-1:0];
            rd_cnt_nxt   = '0;
            found_nxt    = 1'b0;
            best_nxt     = '0;
            best_idx_nxt = '0;
            ext_nxt      = '0;
            state_nxt    = (lim32 == 32'd0) ? ST_FIN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        p_valid_nxt = 1'b1;
        rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
        if (rd_cnt_nxt == lim_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_load) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = grant;
          out_data_nxt  = '0;
          if (grant) begin
            taken_nxt[best_idx_r] = 1'b1;
            out_data_nxt[OUT_IDX_LSB +: INDEX_W]       = out_idx32[INDEX_W-1:0];
            out_data_nxt[OUT_SIZE_LSB +: FIELD_SIZE_W] = out_size32[FIELD_SIZE_W-1:0];
            out_data_nxt[OUT_INT_LSB +: FIELD_SIZE_W]  = out_int32[FIELD_SIZE_W-1:0];
          end else begin
            out_data_nxt[OUT_EXT_LSB +: EXT_W] = ext_r;
            out_data_nxt[OUT_ANY_LSB]          = found_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hole_count_r <= '0;
      taken_r      <= '0;
      p_valid_r    <= 1'b0;
      found_r      <= 1'b0;
      ext_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      taken_r     <= taken_nxt;
      p_valid_r   <= p_valid_nxt;
      found_r     <= found_nxt;
      ext_r       <= ext_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        hole_count_r <= cfg_wdata;
      end
    end
    rd_cnt_r   <= rd_cnt_nxt;
    lim_r      <= lim_nxt;
    req_r      <= req_nxt;
    p_taken_r  <= p_taken_nxt;
    p_idx_r    <= p_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // The scan pointer never runs past the number of holes in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_cnt_r < lim_r))
    else $error("scan pointer past hole limit");

  // Nothing is summed into the external fragmentation before a free hole is seen.
  a_ext_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> (ext_r == '0))
    else $error("free sum without free hole");

  // A granted request marks its hole taken.
  a_grant_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_load && grant) |=> taken_r[$past(best_idx_r)])
    else $error("granted hole not marked taken");

  // A grant never goes to a hole that was already taken.
  a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_load && grant) |-> !taken_r[best_idx_r])
    else $error("grant of a taken hole");

endmodule
`default_nettype wire
